FILE: rtl/core/sha1_stream_hasher_macros.svh
// assertion macros shared by the sha-1 stream hasher
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// same-cycle implication, checked while reset is released
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shs assertion failed");

// next-cycle implication, checked while reset is released
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shs assertion failed");

`endif

FILE: rtl/core/shs_pkg.sv
// types, constants and round functions of the sha-1 stream hasher
package shs_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_chain;
    typedef logic [6:0]       t_round;

    localparam t_chain INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_00_19 = 32'h5A827999;
    localparam t_word K_20_39 = 32'h6ED9EBA1;
    localparam t_word K_40_59 = 32'h8F1BBCDC;
    localparam t_word K_60_79 = 32'hCA62C1D6;

    localparam t_round LAST_ROUND   = 7'd79;
    localparam t_round SCHED_START  = 7'd16;

    localparam logic       CMD_ABSORB    = 1'b0;
    localparam logic       CMD_FINISH    = 1'b1;
    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;
    localparam logic [5:0] BLOCK_LAST    = 6'h3F;
    localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    // status from the round core to the controller
    typedef struct packed {
        logic       done;
        logic [3:0] rd_addr;
    } t_core_stat;

    function automatic t_word round_k(input t_round r);
        t_word k;
        priority if (r < 7'd20) k = K_00_19;
        else if (r < 7'd40)     k = K_20_39;
        else if (r < 7'd60)     k = K_40_59;
        else                    k = K_60_79;
        return k;
    endfunction

    function automatic t_word round_f(input t_round r, input t_word b, input t_word c,
                                      input t_word d);
        t_word f;
        priority if (r < 7'd20) f = (b & c) | (~b & d);
        else if (r < 7'd40)     f = b ^ c ^ d;
        else if (r < 7'd60)     f = (b & c) | (b & d) | (c & d);
        else                    f = b ^ c ^ d;
        return f;
    endfunction

endpackage

FILE: rtl/core/shs_stream_if.sv
// input and output channel interfaces of the sha-1 stream hasher
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

FILE: rtl/core/shs_block_mem.sv
// 16 x 32 block buffer with byte writes and a registered word read
module shs_block_mem (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [5:0]         i_wr_pos,
    input  logic [7:0]         i_wr_byte,
    input  logic [3:0]         i_rd_addr,
    output shs_pkg::t_word     o_rd_data
);

    shs_pkg::t_word r_mem [16];
    shs_pkg::t_word r_rd_data;

    // big-endian: byte lane 0 is the top byte of the word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_pos[5:2]][{~i_wr_pos[1:0], 3'b000} +: 8] <= i_wr_byte;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/shs_round_core.sv
// one sha-1 round per cycle with a 16-word message schedule window
module shs_round_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  shs_pkg::t_chain     i_chain,
    input  shs_pkg::t_word      i_mem_word,
    output shs_pkg::t_chain     o_work,
    output shs_pkg::t_core_stat o_stat
);

    logic             r_run;
    logic             r_done;
    shs_pkg::t_round  r_round;
    shs_pkg::t_chain  r_work;
    shs_pkg::t_word   r_w [16];

    shs_pkg::t_word sched_xor;
    shs_pkg::t_word round_word;
    shs_pkg::t_word temp;

    // r_w[15] is w[i-1], r_w[0] is w[i-16]
    always_comb begin
        sched_xor  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        round_word = (r_round < shs_pkg::SCHED_START) ? i_mem_word
                                                      : {sched_xor[30:0], sched_xor[31]};
        temp = {r_work[0][26:0], r_work[0][31:27]}
             + shs_pkg::round_f(r_round, r_work[1], r_work[2], r_work[3])
             + r_work[4]
             + shs_pkg::round_k(r_round)
             + round_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_round <= '0;
                r_work  <= i_chain;
            end else if (r_run) begin
                r_work[0] <= temp;
                r_work[1] <= r_work[0];
                r_work[2] <= {r_work[1][1:0], r_work[1][31:2]};
                r_work[3] <= r_work[2];
                r_work[4] <= r_work[3];
                for (int k = 0; k < 15; k++) begin
                    r_w[k] <= r_w[k + 1];
                end
                r_w[15] <= round_word;
                r_round <= r_round + 7'd1;
                if (r_round == shs_pkg::LAST_ROUND) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // prefetch the next block word through the buffer's registered read port
    assign o_stat.rd_addr = r_run ? (r_round[3:0] + 4'd1) : 4'd0;
    assign o_stat.done    = r_done;
    assign o_work         = r_work;

endmodule

FILE: rtl/core/sha1_stream_hasher.sv
// top level of the sha-1 stream hasher: controller, chaining words and digest output
//
// SHA-1 over a byte stream. Each absorb transaction (command 0) writes one byte into
// the 64-byte block buffer. The 64th byte of a block starts the compression: a fetch
// of the first block word, the rounds in the round core at one round per cycle, and
// the chaining update on the core's done cycle, all with the input not ready, so no
// byte is taken while a block is compressed. The absorb rate is set by the single
// round unit and the one read port of the block buffer. A finish transaction
// (command 1) pads internally at one byte per cycle between compressions
// (9 to 72 pad bytes, crossing into a second block when fewer than nine bytes of room
// remain), runs one or two compressions, then offers the five digest words on the
// output channel, word 0 first, with last_word set on word 4. The input stays not ready
// until the fifth word transaction completes; then the chaining words and byte count
// return to their initial values for the next message. The message length field holds
// the full 64-bit bit count (byte count modulo 2^61, times eight).

`include "sha1_stream_hasher_macros.svh"

module sha1_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    shs_in_if.sink        i_in,
    shs_out_if.source     o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PREP,
        ST_COMP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_pad_phase;

    t_state               r_state;
    t_pad_phase           r_pad_ph;
    logic [60:0]          r_count;
    logic [63:0]          r_len_bits;
    logic [2:0]           r_len_idx;
    logic                 r_finishing;
    logic                 r_pad_done;
    logic [2:0]           r_word_idx;
    shs_pkg::t_chain      r_chain;

    logic                 in_fire;
    logic                 out_fire;
    logic                 wr_en;
    logic [7:0]           wr_byte;
    logic [7:0]           pad_byte;
    logic [5:0]           pos;
    logic [5:0]           pos_next;
    logic                 core_start;
    shs_pkg::t_word       mem_word;
    shs_pkg::t_chain      core_work;
    shs_pkg::t_core_stat  core_stat;

    // handshakes: input only in idle, output only while presenting the digest
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == ST_OUT);
    assign out_fire    = o_out.valid && o_out.ready;

    assign o_out.digest_word = r_chain[r_word_idx];
    assign o_out.word_index  = r_word_idx;
    assign o_out.last_word   = (r_word_idx == shs_pkg::LAST_WORD_IDX);

    // next buffer position is the low bits of the byte count
    assign pos      = r_count[5:0];
    assign pos_next = pos + 6'd1;

    // pad byte: the 0x80 mark, zero fill, then the bit length most significant byte first
    always_comb begin
        unique case (r_pad_ph)
            PH_MARK: pad_byte = shs_pkg::PAD_MARK;
            PH_LEN:  pad_byte = r_len_bits[63:56];
            default: pad_byte = 8'h00;
        endcase
    end

    // both message bytes and pad bytes enter the buffer through the same write port
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = i_in.data_byte;
        if (r_state == ST_IDLE) begin
            wr_en = in_fire && (i_in.command == shs_pkg::CMD_ABSORB);
        end else if (r_state == ST_PAD) begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
        end
    end

    assign core_start = (r_state == ST_PREP);

    shs_block_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_pos  (pos),
        .i_wr_byte (wr_byte),
        .i_rd_addr (core_stat.rd_addr),
        .o_rd_data (mem_word)
    );

    shs_round_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (core_start),
        .i_chain    (r_chain),
        .i_mem_word (mem_word),
        .o_work     (core_work),
        .o_stat     (core_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pad_ph    <= PH_MARK;
            r_count     <= '0;
            r_len_idx   <= '0;
            r_finishing <= 1'b0;
            r_pad_done  <= 1'b0;
            r_word_idx  <= '0;
            r_chain     <= shs_pkg::INIT_CHAIN;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in.command == shs_pkg::CMD_FINISH) begin
                            // latch the bit length before any pad byte is counted
                            r_len_bits  <= {r_count, 3'b000};
                            r_finishing <= 1'b1;
                            r_pad_ph    <= PH_MARK;
                            r_len_idx   <= '0;
                            r_state     <= ST_PAD;
                        end else begin
                            r_count <= r_count + 61'd1;
                            if (pos == shs_pkg::BLOCK_LAST) begin
                                r_state <= ST_PREP;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_count <= r_count + 61'd1;
                    if (r_pad_ph == PH_LEN) begin
                        r_len_bits <= {r_len_bits[55:0], 8'h00};
                        r_len_idx  <= r_len_idx + 3'd1;
                        if (r_len_idx == shs_pkg::LAST_LEN_BYTE) begin
                            r_pad_done <= 1'b1;
                        end
                    end else if (pos_next == shs_pkg::LEN_OFFSET) begin
                        r_pad_ph <= PH_LEN;
                    end else begin
                        r_pad_ph <= PH_ZERO;
                    end
                    // the last length byte always lands on the last block position
                    if (pos == shs_pkg::BLOCK_LAST) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_COMP;
                end
                ST_COMP: begin
                    if (core_stat.done) begin
                        for (int k = 0; k < 5; k++) begin
                            r_chain[k] <= r_chain[k] + core_work[k];
                        end
                        priority if (r_pad_done) begin
                            r_word_idx <= '0;
                            r_state    <= ST_OUT;
                        end else if (r_finishing) begin
                            r_state <= ST_PAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        if (r_word_idx == shs_pkg::LAST_WORD_IDX) begin
                            // re-initialize for the next message
                            r_chain     <= shs_pkg::INIT_CHAIN;
                            r_count     <= '0;
                            r_finishing <= 1'b0;
                            r_pad_done  <= 1'b0;
                            r_pad_ph    <= PH_MARK;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_word_idx <= r_word_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // input and output channels are never open together
    `SHS_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    // the round core only finishes while the controller waits for it
    `SHS_ASSERT_IMPL(a_done_in_comp, i_clk, i_rst_n, core_stat.done, r_state == ST_COMP)
    // the final digest transaction leaves a fresh message state
    `SHS_ASSERT_NEXT(a_reinit, i_clk, i_rst_n, out_fire && o_out.last_word,
                     (r_count == 61'd0) && (r_state == ST_IDLE))
    // digest is offered only after the length bytes went into the buffer
    `SHS_ASSERT_IMPL(a_out_after_pad, i_clk, i_rst_n, o_out.valid,
                     r_pad_done && (r_word_idx <= shs_pkg::LAST_WORD_IDX))

endmodule
